### design/jit_pkg.sv
// types and constants shared by the job id table
// request and response payload structs, request codes, the foreground state code
package jit_pkg;

	localparam int PID_BITS = 22;
	localparam int KEY_BITS = 5;
	localparam int TYPE_BITS = 3;
	localparam int ST_BITS = 2;
	// stored job ids can climb past the table depth through delete then add
	localparam int JID_BITS = 32;

	localparam logic [TYPE_BITS-1:0] REQ_ADD  = 3'd0;
	localparam logic [TYPE_BITS-1:0] REQ_DEL  = 3'd1;
	localparam logic [TYPE_BITS-1:0] REQ_SET  = 3'd2;
	localparam logic [TYPE_BITS-1:0] REQ_LOOK = 3'd3;
	localparam logic [TYPE_BITS-1:0] REQ_FG   = 3'd4;

	localparam logic [ST_BITS-1:0] ST_FG = 2'd1;

	typedef struct packed {
		logic [TYPE_BITS-1:0] req_type;
		logic                 by_jid;
		logic [PID_BITS-1:0]  proc_id;
		logic [KEY_BITS-1:0]  job_key;
		logic [ST_BITS-1:0]   new_state;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [PID_BITS-1:0] out_pid;
		logic [KEY_BITS-1:0] out_jid;
		logic [ST_BITS-1:0]  out_state;
	} rsp_t;

endpackage

### design/job_id_table.sv
// job id table top level: one synchronous table memory scanned once per request
// a request is scanned slot by slot through the registered read port, then written back
// new requests are taken only in idle, after the scan and write-back of the last one
// a waiting response does not block the next request until its write-back step
// reset: control, valid bits and response valid clear at once, next id goes to 1
// depends on jit_pkg
module job_id_table #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  jit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output jit_pkg::rsp_t rsp
);
	import jit_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int JID_W = JID_BITS;
	localparam int CMP_W = (JID_W > KEY_BITS) ? JID_W : KEY_BITS;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	typedef struct packed {
		logic [PID_BITS-1:0] pid;
		logic [JID_W-1:0]    jid;
		logic [ST_BITS-1:0]  st;
	} ent_t;

	ent_t mem [TABLE_DEPTH];

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	req_t                   req_q;
	logic [JID_W-1:0]       nid_q;
	logic                   iss_s1;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	ent_t                   rd_data_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       idx_q;
	ent_t                   ent_q;
	logic [JID_W-1:0]       max_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	ent_t             e_cur;
	logic             match;
	logic             rd_en;
	logic             fin_go;
	logic             we;
	ent_t             wr_ent;
	ent_t             show;
	logic [JID_W-1:0] nid_d;
	logic [JID_W-1:0] nid_inc;
	rsp_t             rsp_d;

	assign req_ready = (state_q == S_IDLE);
	assign rd_en     = (state_q == S_SCAN) && (cnt_q != CNT_W'(TABLE_DEPTH));
	assign fin_go    = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// match test on the entry coming out of memory
	always_comb begin
		e_cur = vld_s1 ? rd_data_s1 : '0;
		case (req_q.req_type) inside
			REQ_ADD: match = (req_q.proc_id != '0) && (e_cur.pid == '0);
			REQ_DEL: match = (req_q.proc_id != '0) && (e_cur.pid == req_q.proc_id);
			REQ_SET, REQ_LOOK: begin
				if (req_q.by_jid) begin
					match = (req_q.job_key != '0) &&
						(CMP_W'(e_cur.jid) == CMP_W'(req_q.job_key));
				end else begin
					match = (req_q.proc_id != '0) && (e_cur.pid == req_q.proc_id);
				end
			end
			REQ_FG:  match = (e_cur.st == ST_FG);
			default: match = 1'b0;
		endcase
	end

	// write-back and response
	always_comb begin
		nid_inc = nid_q + JID_W'(1);
		nid_d   = nid_q;
		we      = 1'b0;
		wr_ent  = ent_q;
		show    = ent_q;
		case (req_q.req_type)
			REQ_ADD: begin
				wr_ent.pid = req_q.proc_id;
				wr_ent.jid = nid_q;
				wr_ent.st  = req_q.new_state;
				show       = wr_ent;
				we         = found_q;
				if (found_q) begin
					nid_d = (nid_inc > JID_W'(TABLE_DEPTH)) ? JID_W'(1) : nid_inc;
				end
			end
			REQ_DEL: begin
				wr_ent = '0;
				we     = found_q;
				if (found_q) begin
					nid_d = max_q + JID_W'(1);
				end
			end
			REQ_SET: begin
				wr_ent.st = req_q.new_state;
				show      = wr_ent;
				we        = found_q;
			end
			default: we = 1'b0;
		endcase
		rsp_d = '0;
		if (found_q) begin
			rsp_d.ok        = 1'b1;
			rsp_d.out_pid   = show.pid;
			rsp_d.out_jid   = KEY_BITS'(show.jid);
			rsp_d.out_state = show.st;
		end
	end

	// table memory, one read and one write port
	always_ff @(posedge clk) begin
		if (fin_go && we) begin
			mem[idx_q] <= wr_ent;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
			vld_s1 <= vld_q[cnt_q[IDX_W-1:0]];
		end
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (fin_go) begin
			rsp_q <= rsp_d;
		end
		if (req_valid && req_ready) begin
			max_q <= '0;
		end else if (state_q == S_SCAN && iss_s1) begin
			if (match && !found_q) begin
				idx_q <= idx_s1;
				ent_q <= e_cur;
			end else if (e_cur.jid > max_q) begin
				max_q <= e_cur.jid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vld_q       <= '0;
			nid_q       <= JID_W'(1);
			iss_s1      <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			iss_s1 <= rd_en;
			if (rsp_valid_q && rsp_ready && !fin_go) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (iss_s1 && match) begin
						found_q <= 1'b1;
					end
					if (!rd_en && !iss_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b1;
						nid_q       <= nid_d;
						if (we) begin
							vld_q[idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_nid_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		nid_q != '0)
		else $error("next job id is zero");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.ok |-> rsp_q.out_pid == '0 && rsp_q.out_jid == '0 &&
			rsp_q.out_state == '0)
		else $error("failed response carries nonzero fields");

	a_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && we |-> found_q)
		else $error("table write without a matching slot");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_SCAN && cnt_q == '0)
		else $error("accepted request did not start a scan");

endmodule

### dv/job_id_table_test.sv
// self-checking testbench for job_id_table: directed and random requests
// with random idling on both sides, responses checked against a shadow table
// depends on jit_pkg and the job_id_table design

class job_table_shadow;
	localparam int SLOTS = 16;

	logic [jit_pkg::PID_BITS-1:0] slot_pid [SLOTS];
	logic [jit_pkg::JID_BITS-1:0] slot_jid [SLOTS];
	logic [jit_pkg::ST_BITS-1:0]  slot_st  [SLOTS];
	logic [jit_pkg::JID_BITS-1:0] next_jid;
	jit_pkg::rsp_t                due_rsp [$];
	int                           error_count;

	function new();
		for (int i = 0; i < SLOTS; i++) begin
			slot_pid[i] = '0;
			slot_jid[i] = '0;
			slot_st[i]  = '0;
		end
		next_jid    = 1;
		error_count = 0;
	endfunction

	function int find_pid(logic [jit_pkg::PID_BITS-1:0] pid);
		if (pid == '0) begin
			return -1;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_pid[i] == pid) begin
				return i;
			end
		end
		return -1;
	endfunction

	function int find_jid(logic [jit_pkg::KEY_BITS-1:0] jid);
		if (jid == '0) begin
			return -1;
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_jid[i] == jid) begin
				return i;
			end
		end
		return -1;
	endfunction

	// apply one accepted request and queue the response it should produce
	function void take_request(jit_pkg::req_t r);
		int                           s;
		jit_pkg::rsp_t                e;
		logic [jit_pkg::JID_BITS-1:0] top;
		s = -1;
		case (r.req_type)
			jit_pkg::REQ_ADD: begin
				if (r.proc_id != '0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (s < 0 && slot_pid[i] == '0) begin
							s = i;
						end
					end
				end
				if (s >= 0) begin
					slot_pid[s] = r.proc_id;
					slot_st[s]  = r.new_state;
					slot_jid[s] = next_jid;
					next_jid    = next_jid + 1;
					if (next_jid > SLOTS) begin
						next_jid = 1;
					end
				end
			end
			jit_pkg::REQ_DEL: begin
				s = find_pid(r.proc_id);
			end
			jit_pkg::REQ_SET: begin
				s = r.by_jid ? find_jid(r.job_key) : find_pid(r.proc_id);
				if (s >= 0) begin
					slot_st[s] = r.new_state;
				end
			end
			jit_pkg::REQ_LOOK: begin
				s = r.by_jid ? find_jid(r.job_key) : find_pid(r.proc_id);
			end
			jit_pkg::REQ_FG: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (s < 0 && slot_st[i] == jit_pkg::ST_FG) begin
						s = i;
					end
				end
			end
			default: begin
				s = -1;
			end
		endcase
		e = '0;
		if (s >= 0) begin
			e.ok        = 1'b1;
			e.out_pid   = slot_pid[s];
			e.out_jid   = slot_jid[s][jit_pkg::KEY_BITS-1:0];
			e.out_state = slot_st[s];
		end
		// delete reports the entry as it was, then clears it
		if (r.req_type == jit_pkg::REQ_DEL && s >= 0) begin
			slot_pid[s] = '0;
			slot_jid[s] = '0;
			slot_st[s]  = '0;
			top = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_jid[i] > top) begin
					top = slot_jid[i];
				end
			end
			next_jid = top + 1;
		end
		due_rsp.push_back(e);
	endfunction

	function void check_response(jit_pkg::rsp_t a);
		jit_pkg::rsp_t e;
		if (due_rsp.size() == 0) begin
			$error("response with no request outstanding: ok=%0d pid=%0d jid=%0d state=%0d",
				a.ok, a.out_pid, a.out_jid, a.out_state);
			error_count++;
			return;
		end
		e = due_rsp.pop_front();
		if (a.ok !== e.ok) begin
			$error("ok: expected %0d, got %0d", e.ok, a.ok);
			error_count++;
		end
		if (a.out_pid !== e.out_pid) begin
			$error("out_pid: expected %0d, got %0d", e.out_pid, a.out_pid);
			error_count++;
		end
		if (a.out_jid !== e.out_jid) begin
			$error("out_jid: expected %0d, got %0d", e.out_jid, a.out_jid);
			error_count++;
		end
		if (a.out_state !== e.out_state) begin
			$error("out_state: expected %0d, got %0d", e.out_state, a.out_state);
			error_count++;
		end
	endfunction
endclass

module job_id_table_test;
	import jit_pkg::*;

	localparam logic [ST_BITS-1:0]   ST_EMPTY = 2'd0;
	localparam logic [ST_BITS-1:0]   ST_BG    = 2'd2;
	localparam logic [ST_BITS-1:0]   ST_STOP  = 2'd3;
	localparam logic [TYPE_BITS-1:0] REQ_SPARE_FIRST = 3'd5;
	localparam logic [TYPE_BITS-1:0] REQ_SPARE_MID   = 3'd6;
	localparam logic [TYPE_BITS-1:0] REQ_SPARE_LAST  = 3'd7;
	localparam logic [PID_BITS-1:0]  PID_MAX = {PID_BITS{1'b1}};
	localparam logic [KEY_BITS-1:0]  KEY_MAX = {KEY_BITS{1'b1}};
	localparam int                   KEY_TOP = 17;
	localparam int                   SLOTS = 16;
	localparam int                   PHASE_ITEMS = 500;
	localparam int                   SETTLE_CYCLES = 40;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	int    send_idle = 0;
	int    recv_idle = 0;

	job_table_shadow shadow = new();

	job_id_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			shadow.check_response(rsp);
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic req_t mk_req(logic [TYPE_BITS-1:0] kind, logic byj,
			logic [PID_BITS-1:0] pid, logic [KEY_BITS-1:0] key, logic [ST_BITS-1:0] st);
		req_t r;
		r.req_type  = kind;
		r.by_jid    = byj;
		r.proc_id   = pid;
		r.job_key   = key;
		r.new_state = st;
		return r;
	endfunction

	// keys mostly taken from shadow table slots so that matches are common
	function automatic req_t rand_req(int add_w);
		req_t r;
		int   pick;
		r.by_jid    = 1'($urandom_range(1));
		r.new_state = ST_BITS'($urandom_range(3));
		pick = $urandom_range(99);
		if (pick < 60) begin
			r.proc_id = shadow.slot_pid[$urandom_range(SLOTS - 1)];
		end else if (pick < 85) begin
			r.proc_id = PID_BITS'($urandom_range(1, 24));
		end else if (pick < 95) begin
			r.proc_id = PID_BITS'($urandom);
		end else begin
			r.proc_id = $urandom_range(1) ? PID_MAX : '0;
		end
		pick = $urandom_range(99);
		if (pick < 60) begin
			r.job_key = KEY_BITS'(shadow.slot_jid[$urandom_range(SLOTS - 1)]);
		end else if (pick < 90) begin
			r.job_key = KEY_BITS'($urandom_range(1, KEY_TOP));
		end else begin
			r.job_key = KEY_BITS'($urandom_range(KEY_MAX));
		end
		pick = $urandom_range(add_w + 59);
		if (pick < add_w) begin
			r.req_type = REQ_ADD;
		end else if (pick < add_w + 20) begin
			r.req_type = REQ_DEL;
		end else if (pick < add_w + 35) begin
			r.req_type = REQ_SET;
		end else if (pick < add_w + 50) begin
			r.req_type = REQ_LOOK;
		end else if (pick < add_w + 58) begin
			r.req_type = REQ_FG;
		end else begin
			r.req_type = TYPE_BITS'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
		end
		return r;
	endfunction

	task automatic send_req(req_t r);
		if ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		shadow.take_request(r);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (shadow.due_rsp.size() != 0);
	endtask

	initial begin
		int add_w;
		add_w = 40;
		repeat (7) @(posedge clk);
		arst_n    <= 1'b1;
		send_idle = 34;
		recv_idle <= 60;

		send_req(mk_req(REQ_FG,   1'b0, '0,      5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_LOOK, 1'b1, '0,      5'd1,    ST_EMPTY));
		send_req(mk_req(REQ_ADD,  1'b0, '0,      5'd0,    ST_FG));
		send_req(mk_req(REQ_ADD,  1'b0, PID_MAX, 5'd0,    ST_FG));
		send_req(mk_req(REQ_ADD,  1'b1, 22'd5,   KEY_MAX, ST_EMPTY));
		send_req(mk_req(REQ_ADD,  1'b0, 22'd5,   5'd0,    ST_BG));
		send_req(mk_req(REQ_LOOK, 1'b0, 22'd5,   5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_LOOK, 1'b1, '0,      5'd3,    ST_EMPTY));
		send_req(mk_req(REQ_LOOK, 1'b1, PID_MAX, 5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_SET,  1'b1, '0,      5'd2,    ST_STOP));
		send_req(mk_req(REQ_SET,  1'b0, '0,      5'd1,    ST_FG));
		send_req(mk_req(REQ_SET,  1'b0, PID_MAX, 5'd0,    ST_BG));
		send_req(mk_req(REQ_FG,   1'b1, PID_MAX, KEY_MAX, ST_STOP));
		send_req(mk_req(REQ_SET,  1'b0, 22'd5,   5'd0,    ST_FG));
		send_req(mk_req(REQ_FG,   1'b0, '0,      5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_SET,  1'b1, '0,      5'd1,    ST_EMPTY));
		send_req(mk_req(REQ_DEL,  1'b0, 22'd5,   5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_DEL,  1'b0, 22'd5,   5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_DEL,  1'b0, 22'd77,  5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_DEL,  1'b0, '0,      5'd0,    ST_EMPTY));
		send_req(mk_req(REQ_SPARE_FIRST, 1'b1, PID_MAX, 5'd1, ST_FG));
		send_req(mk_req(REQ_SPARE_MID,   1'b0, 22'd5,   5'd1, ST_BG));
		send_req(mk_req(REQ_SPARE_LAST, 1'b1, PID_MAX, KEY_MAX, ST_STOP));
		send_req(mk_req(REQ_LOOK, 1'b1, '0,      KEY_MAX, ST_EMPTY));
		send_req(mk_req(REQ_SET,  1'b1, '0,      5'd17,   ST_STOP));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 34;
					recv_idle <= 60;
				end
				1: begin
					send_idle = 60;
					recv_idle <= 34;
				end
				default: begin
					send_idle = 0;
					recv_idle <= 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// swing between filling and emptying the table
				if (n % 64 == 0) begin
					add_w = $urandom_range(10, 70);
				end
				send_req(rand_req(add_w));
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

### filelist.f
design/jit_pkg.sv
design/job_id_table.sv
dv/job_id_table_test.sv
